@@ design/fsle_pkg.sv @@
// ----------------------------------------------------------------------------
// fsle_pkg
// Shared types and field widths of the first-seen label enumerator.
// ----------------------------------------------------------------------------
package fsle_pkg;

  localparam int LABEL_W   = 24;
  localparam int POINT_W   = 20;
  localparam int CLUSTER_W = 6;

  // input transaction
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               scan_start;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster_number;
    logic [POINT_W-1:0]   point_number;
    logic                 opened_new;
    logic                 table_overflow;
  } out_item_t;

  // lookup token walking down the cell chain
  typedef struct packed {
    logic                 vld;
    logic                 restart;  // scan starts with this point: table seen as empty
    logic                 found;    // matched or appended further up the chain
    logic                 fresh;    // appended by a cell
    logic [LABEL_W-1:0]   label;
    logic [CLUSTER_W-1:0] idx;
  } token_t;

endpackage

@@ design/fsle_cell.sv @@
// ----------------------------------------------------------------------------
// fsle_cell
// One table entry: compares the passing token, or takes its label when this
// is the first free entry, then hands the token to the next cell.
// ----------------------------------------------------------------------------
module fsle_cell #(
  parameter int CELL_IDX = 0,
  parameter int USED_W   = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [USED_W-1:0] used_i,
  input  fsle_pkg::token_t tok_i,
  output fsle_pkg::token_t tok_o
);
  import fsle_pkg::*;

  logic [LABEL_W-1:0] entry_r;
  token_t             tok_r;
  token_t             tok_nxt;
  logic [USED_W-1:0]  eff_used;
  logic               occupied;
  logic               take;

  assign eff_used = tok_i.restart ? '0 : used_i;
  assign occupied = USED_W'(CELL_IDX) < eff_used;
  // entries fill in order, so the first free cell reached unmatched appends
  assign take     = tok_i.vld && !tok_i.found && !occupied;

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.vld && !tok_i.found) begin
      if (occupied && (entry_r == tok_i.label)) begin
        tok_nxt.found = 1'b1;
        tok_nxt.idx   = CLUSTER_W'(CELL_IDX);
      end else if (!occupied) begin
        tok_nxt.found = 1'b1;
        tok_nxt.fresh = 1'b1;
        tok_nxt.idx   = CLUSTER_W'(CELL_IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry_r <= tok_i.label;
    end
  end

  assign tok_o = tok_r;

endmodule

@@ design/first_seen_label_enumerator_top.sv @@
// ----------------------------------------------------------------------------
// first_seen_label_enumerator_top
// Gives every point label a dense cluster number in order of first appearance.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_item (label, scan_start) and raise start; the
//   transaction is taken at a rising edge with start high and busy low.
//   scan_start empties the label table and restarts the point count.
//   Result channel: out_strobe is high for exactly one cycle with out_result
//   (cluster_number, point_number, opened_new, table_overflow). The receiver
//   cannot stall, so each result must be captured in its strobe cycle.
// Table chain:
//   The table is a chain of MAX_CLUSTERS cells, one entry each. A lookup
//   token enters cell 0 at acceptance and advances one cell per cycle; the
//   result is registered and strobed after the token leaves the last cell.
//   busy stays high from acceptance until the token leaves the chain, so a
//   new transaction is taken only after the previous one has left the chain.
// Table full: an unseen label is not stored; it gets cluster MAX_CLUSTERS-1
//   (masked to the field) with both opened_new and table_overflow set.
// Reset: table empty, point counter zero, no token in flight, busy low. The
//   first point after reset behaves as if scan_start were set.
// ----------------------------------------------------------------------------
module first_seen_label_enumerator_top #(
  parameter int MAX_CLUSTERS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fsle_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output fsle_pkg::out_item_t out_result
);
  import fsle_pkg::*;

  localparam int USED_W = $clog2(MAX_CLUSTERS + 1);

  logic                accept;
  token_t              head_tok;
  token_t              chain_q [MAX_CLUSTERS];
  token_t              exit_tok;

  logic [USED_W-1:0]   used_r;
  logic [USED_W-1:0]   used_nxt;
  logic [POINT_W-1:0]  point_cnt_r;
  logic [POINT_W-1:0]  point_cnt_nxt;
  logic [POINT_W-1:0]  this_point;
  logic [POINT_W-1:0]  hold_point_r;
  logic                busy_r;
  logic                busy_nxt;
  logic                out_strobe_r;
  out_item_t           out_r;
  out_item_t           out_nxt;
  logic                appended;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // token entering the chain
  always_comb begin
    head_tok         = '0;
    head_tok.vld     = accept;
    head_tok.restart = in_item.scan_start;
    head_tok.label   = in_item.label;
  end

  // row of table cells, each handing the token to its neighbour
  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    if (g == 0) begin : g_first
      fsle_cell #(.CELL_IDX(g), .USED_W(USED_W)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .used_i (used_r),
        .tok_i  (head_tok),
        .tok_o  (chain_q[g])
      );
    end else begin : g_rest
      fsle_cell #(.CELL_IDX(g), .USED_W(USED_W)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .used_i (used_r),
        .tok_i  (chain_q[g-1]),
        .tok_o  (chain_q[g])
      );
    end
  end

  assign exit_tok = chain_q[MAX_CLUSTERS-1];
  assign appended = exit_tok.vld && exit_tok.fresh;

  // point numbering: captured at acceptance, held while the token walks
  assign this_point    = in_item.scan_start ? '0 : point_cnt_r;
  assign point_cnt_nxt = accept ? this_point + POINT_W'(1) : point_cnt_r;

  // fill count is settled when the token leaves the chain
  always_comb begin
    used_nxt = used_r;
    if (exit_tok.vld) begin
      if (exit_tok.restart) begin
        used_nxt = appended ? USED_W'(1) : '0;
      end else if (appended) begin
        used_nxt = used_r + USED_W'(1);
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (exit_tok.vld) begin
      busy_nxt = 1'b0;
    end
  end

  // result: an unmatched token that ran off the end means the table is full
  always_comb begin
    out_nxt.cluster_number = exit_tok.found ? exit_tok.idx : CLUSTER_W'(MAX_CLUSTERS - 1);
    out_nxt.point_number   = hold_point_r;
    out_nxt.opened_new     = exit_tok.fresh || !exit_tok.found;
    out_nxt.table_overflow = !exit_tok.found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      point_cnt_r  <= '0;
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      used_r       <= used_nxt;
      point_cnt_r  <= point_cnt_nxt;
      busy_r       <= busy_nxt;
      out_strobe_r <= exit_tok.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_point_r <= this_point;
    end
    if (exit_tok.vld) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

endmodule
